@@ design/gn2_pkg.sv @@
// Shared types, widths and codes for the 2D gradient noise block.
package gn2_pkg;

   // Command codes carried on req_command
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // Configuration register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam int MOD_W   = 7;          // wrap modulus / remainder width
   localparam int CELL_W  = 15;         // integer part of an absolute coordinate
   localparam int FRAC_W  = 16;         // fractional part, Q0.16
   localparam int GRAD_W  = 16;         // gradient component, Q2.13
   localparam int ENTRY_W = 2 * GRAD_W; // table entry: y in upper half, x in lower
   localparam int DOT_W   = 33;         // one component product
   localparam int ACC_W   = 36;         // corner dot products and blended rows
   localparam int PROD_W  = 54;         // blend before rounding
   localparam int REM_STEPS = 5;        // remainder bits resolved per stage

   localparam logic [MOD_W-1:0] GRID_RESET = 7'd64;

   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [ENTRY_W-1:0]       entry_type;

endpackage

@@ design/gradient_noise_2d.sv @@
// Top level of the 2D gradient noise block: eleven-stage pipeline.
//
//  channel | direction | handshake              | beat
//  req_    | in        | req_valid / req_ready  | write entry or evaluate point
//  rsp_    | out       | rsp_valid / rsp_ready  | one noise value per evaluate
//  csr_    | in        | csr_write_enable       | grid width / height in use
//
// One beat enters every cycle unless the output stalls; an evaluate beat gives its result at rsp_.
// The stages hold the 15-step cell remainder (three stages), the table read and the
// two blend multiplications each followed by a rounding stage.
// Write beats update the table at the read stage and are dropped there.
// Reset empties the pipeline and sets both grid sizes to 64; the table is not cleared.
// A stalled output holds only the stages that are full behind it; bubbles are squeezed out.
module gradient_noise_2d #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [5:0]  req_table_col,
   input  logic [5:0]  req_table_row,
   input  logic signed [15:0] req_gradient_x,
   input  logic signed [15:0] req_gradient_y,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_noise_value,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [6:0]  csr_write_data
);
   import gn2_pkg::*;

   localparam int DEPTH = GRID_COLS * GRID_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int NS    = 11;
   localparam acc_type  HALF13 = ACC_W'(4096);
   localparam prod_type HALF16 = PROD_W'(32768);
   localparam acc_type  SAT_HI = ACC_W'(64'sh7FFFFFFF);
   localparam acc_type  SAT_LO = -ACC_W'(64'sh80000000);

   // ---------------- configuration ----------------
   logic [MOD_W-1:0] grid_w_ff, grid_h_ff;
   logic [MOD_W-1:0] wmod, hmod;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= GRID_RESET;
         grid_h_ff <= GRID_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_w_ff <= csr_write_data;
            CSR_GRID_HEIGHT: grid_h_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grid_w_ff == '0) wmod = MOD_W'(1);
      else if (32'(grid_w_ff) > GRID_COLS) wmod = MOD_W'(GRID_COLS);
      else wmod = grid_w_ff;
      if (grid_h_ff == '0) hmod = MOD_W'(1);
      else if (32'(grid_h_ff) > GRID_ROWS) hmod = MOD_W'(GRID_ROWS);
      else hmod = grid_h_ff;
   end

   // ---------------- pipeline control ----------------
   logic [NS:1]   vld_ff;
   logic [NS+1:1] rdy;

   always_comb begin
      rdy[NS+1] = rsp_ready;
      for (int k = NS; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_ready = rdy[1];

   // cmd through stage 6, write payload travels to stage 5
   logic             cmd_ff [1:6];
   logic [5:0]       col_ff [1:4];
   logic [5:0]       row_ff [1:4];
   logic [GRAD_W-1:0] gx_ff [1:4];
   logic [GRAD_W-1:0] gy_ff [1:4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[1]) vld_ff[1] <= req_valid;
         for (int k = 2; k <= NS; k++) begin
            if (rdy[k]) begin
               // drop write beats once they have reached the table
               if (k == 7) vld_ff[k] <= vld_ff[6] && (cmd_ff[6] == CMD_EVAL);
               else        vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 1: absolute value ----------------
   logic [CELL_W+FRAC_W-1:0] ax_in, ay_in, ax_ff, ay_ff;

   always_comb begin
      if (req_coord_x == 32'sh80000000) ax_in = '1;
      else if (req_coord_x[31])         ax_in = 31'(-req_coord_x);
      else                              ax_in = req_coord_x[30:0];
      if (req_coord_y == 32'sh80000000) ay_in = '1;
      else if (req_coord_y[31])         ay_in = 31'(-req_coord_y);
      else                              ay_in = req_coord_y[30:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
      end
   end

   // ---------------- stages 2..4: cell remainder ----------------
   logic [MOD_W-1:0]  rx_ff [2:4];
   logic [MOD_W-1:0]  ry_ff [2:4];
   logic [MOD_W-1:0]  rx_in [2:4];
   logic [MOD_W-1:0]  ry_in [2:4];
   logic [CELL_W-1:0] cx_ff [2:4];
   logic [CELL_W-1:0] cy_ff [2:4];
   logic [FRAC_W-1:0] fx_ff [2:6];
   logic [FRAC_W-1:0] fy_ff [2:6];

   gn2_rem_step u_rx2 (.rem_in('0), .bits_in(ax_ff[30:26]), .divisor(wmod),
                       .rem_out(rx_in[2]));
   gn2_rem_step u_ry2 (.rem_in('0), .bits_in(ay_ff[30:26]), .divisor(hmod),
                       .rem_out(ry_in[2]));
   gn2_rem_step u_rx3 (.rem_in(rx_ff[2]), .bits_in(cx_ff[2][9:5]), .divisor(wmod),
                       .rem_out(rx_in[3]));
   gn2_rem_step u_ry3 (.rem_in(ry_ff[2]), .bits_in(cy_ff[2][9:5]), .divisor(hmod),
                       .rem_out(ry_in[3]));
   gn2_rem_step u_rx4 (.rem_in(rx_ff[3]), .bits_in(cx_ff[3][4:0]), .divisor(wmod),
                       .rem_out(rx_in[4]));
   gn2_rem_step u_ry4 (.rem_in(ry_ff[3]), .bits_in(cy_ff[3][4:0]), .divisor(hmod),
                       .rem_out(ry_in[4]));

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         cmd_ff[1] <= req_command;
         col_ff[1] <= req_table_col;
         row_ff[1] <= req_table_row;
         gx_ff[1]  <= req_gradient_x;
         gy_ff[1]  <= req_gradient_y;
      end
      if (rdy[2]) begin
         rx_ff[2]  <= rx_in[2];
         ry_ff[2]  <= ry_in[2];
         cx_ff[2]  <= ax_ff[30:16];
         cy_ff[2]  <= ay_ff[30:16];
         fx_ff[2]  <= ax_ff[15:0];
         fy_ff[2]  <= ay_ff[15:0];
      end
      for (int k = 2; k <= 4; k++) begin
         if (rdy[k]) begin
            cmd_ff[k] <= cmd_ff[k-1];
            col_ff[k] <= col_ff[k-1];
            row_ff[k] <= row_ff[k-1];
            gx_ff[k]  <= gx_ff[k-1];
            gy_ff[k]  <= gy_ff[k-1];
         end
      end
      for (int k = 3; k <= 4; k++) begin
         if (rdy[k]) begin
            rx_ff[k] <= rx_in[k];
            ry_ff[k] <= ry_in[k];
            cx_ff[k] <= cx_ff[k-1];
            cy_ff[k] <= cy_ff[k-1];
            fx_ff[k] <= fx_ff[k-1];
            fy_ff[k] <= fy_ff[k-1];
         end
      end
      for (int k = 5; k <= 6; k++) begin
         if (rdy[k]) begin
            cmd_ff[k] <= cmd_ff[k-1];
            fx_ff[k]  <= fx_ff[k-1];
            fy_ff[k]  <= fy_ff[k-1];
         end
      end
   end

   // ---------------- stage 5: corner and write addresses ----------------
   logic [MOD_W-1:0] cx1_in, cy1_in;
   logic [AW-1:0]    a00_ff, a10_ff, a01_ff, a11_ff, wa_ff;
   entry_type        wd_ff;
   logic             wok_ff;

   always_comb begin
      cx1_in = (rx_ff[4] + MOD_W'(1) == wmod) ? '0 : rx_ff[4] + MOD_W'(1);
      cy1_in = (ry_ff[4] + MOD_W'(1) == hmod) ? '0 : ry_ff[4] + MOD_W'(1);
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         a00_ff <= AW'(32'(ry_ff[4]) * GRID_COLS + 32'(rx_ff[4]));
         a10_ff <= AW'(32'(ry_ff[4]) * GRID_COLS + 32'(cx1_in));
         a01_ff <= AW'(32'(cy1_in) * GRID_COLS + 32'(rx_ff[4]));
         a11_ff <= AW'(32'(cy1_in) * GRID_COLS + 32'(cx1_in));
         wa_ff  <= AW'(32'(row_ff[4]) * GRID_COLS + 32'(col_ff[4]));
         wd_ff  <= {gy_ff[4], gx_ff[4]};
         wok_ff <= (32'(col_ff[4]) < GRID_COLS) && (32'(row_ff[4]) < GRID_ROWS);
      end
   end

   // ---------------- stage 6: table read ----------------
   logic      tbl_wr;
   entry_type g00, g10, g01, g11;

   assign tbl_wr = rdy[6] && vld_ff[5] && (cmd_ff[5] == CMD_WRITE) && wok_ff;

   gn2_grad_mem #(.DEPTH(DEPTH)) u_mem00 (.clock(clock), .wr_en(tbl_wr), .wr_addr(wa_ff),
      .wr_data(wd_ff), .rd_en(rdy[6]), .rd_addr(a00_ff), .rd_data(g00));
   gn2_grad_mem #(.DEPTH(DEPTH)) u_mem10 (.clock(clock), .wr_en(tbl_wr), .wr_addr(wa_ff),
      .wr_data(wd_ff), .rd_en(rdy[6]), .rd_addr(a10_ff), .rd_data(g10));
   gn2_grad_mem #(.DEPTH(DEPTH)) u_mem01 (.clock(clock), .wr_en(tbl_wr), .wr_addr(wa_ff),
      .wr_data(wd_ff), .rd_en(rdy[6]), .rd_addr(a01_ff), .rd_data(g01));
   gn2_grad_mem #(.DEPTH(DEPTH)) u_mem11 (.clock(clock), .wr_en(tbl_wr), .wr_addr(wa_ff),
      .wr_data(wd_ff), .rd_en(rdy[6]), .rd_addr(a11_ff), .rd_data(g11));

   // ---------------- stage 7: corner dot products ----------------
   logic signed [FRAC_W:0] dx0, dx1, dy0, dy1;
   logic signed [DOT_W-1:0] p00x, p00y, p10x, p10y, p01x, p01y, p11x, p11y;
   acc_type n00_ff, n10_ff, n01_ff, n11_ff;
   logic [FRAC_W-1:0] fx7_ff, fy7_ff, fy8_ff, fy9_ff;

   always_comb begin
      dx0 = {1'b0, fx_ff[6]};
      dx1 = {1'b1, fx_ff[6]};   // fx - 1.0
      dy0 = {1'b0, fy_ff[6]};
      dy1 = {1'b1, fy_ff[6]};
      p00x = dx0 * $signed(g00[GRAD_W-1:0]);
      p00y = dy0 * $signed(g00[ENTRY_W-1:GRAD_W]);
      p10x = dx1 * $signed(g10[GRAD_W-1:0]);
      p10y = dy0 * $signed(g10[ENTRY_W-1:GRAD_W]);
      p01x = dx0 * $signed(g01[GRAD_W-1:0]);
      p01y = dy1 * $signed(g01[ENTRY_W-1:GRAD_W]);
      p11x = dx1 * $signed(g11[GRAD_W-1:0]);
      p11y = dy1 * $signed(g11[ENTRY_W-1:GRAD_W]);
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         n00_ff <= ACC_W'(p00x) + ACC_W'(p00y);
         n10_ff <= ACC_W'(p10x) + ACC_W'(p10y);
         n01_ff <= ACC_W'(p01x) + ACC_W'(p01y);
         n11_ff <= ACC_W'(p11x) + ACC_W'(p11y);
         fx7_ff <= fx_ff[6];
         fy7_ff <= fy_ff[6];
      end
   end

   // ---------------- stage 8: blend along x ----------------
   logic signed [FRAC_W:0] wx, wy;
   prod_type bx0_in, bx1_in, bx0_ff, bx1_ff;
   acc_type  d0, d1;

   always_comb begin
      wx = {1'b0, fx7_ff};
      d0 = n10_ff - n00_ff;
      d1 = n11_ff - n01_ff;
      bx0_in = (PROD_W'(n00_ff) <<< FRAC_W) + d0 * wx;
      bx1_in = (PROD_W'(n01_ff) <<< FRAC_W) + d1 * wx;
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         bx0_ff <= bx0_in;
         bx1_ff <= bx1_in;
         fy8_ff <= fy7_ff;
      end
   end

   // ---------------- stage 9: round rows ----------------
   acc_type row0_ff, row1_ff;

   always_ff @(posedge clock) begin
      if (rdy[9]) begin
         row0_ff <= ACC_W'((bx0_ff + HALF16) >>> FRAC_W);
         row1_ff <= ACC_W'((bx1_ff + HALF16) >>> FRAC_W);
         fy9_ff  <= fy8_ff;
      end
   end

   // ---------------- stage 10: blend along y ----------------
   prod_type by_in, by_ff;
   acc_type  dr;

   always_comb begin
      wy = {1'b0, fy9_ff};
      dr = row1_ff - row0_ff;
      by_in = (PROD_W'(row0_ff) <<< FRAC_W) + dr * wy;
   end

   always_ff @(posedge clock) begin
      if (rdy[10]) begin
         by_ff <= by_in;
      end
   end

   // ---------------- stage 11: round to Q.16 and saturate ----------------
   acc_type r29, v16;
   logic signed [31:0] out_in, out_ff;

   always_comb begin
      r29 = ACC_W'((by_ff + HALF16) >>> FRAC_W);
      v16 = (r29 + HALF13) >>> 13;
      if (v16 > SAT_HI)      out_in = 32'sh7FFFFFFF;
      else if (v16 < SAT_LO) out_in = 32'sh80000000;
      else                   out_in = v16[31:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[11]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = vld_ff[NS];
   assign rsp_noise_value = out_ff;

   // ---------------- assertions ----------------
   a_write_dropped: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[6] && cmd_ff[6] == CMD_WRITE && rdy[7]) |=> !vld_ff[7])
      else $error("write beat passed the table stage");

   a_rem_x_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && cmd_ff[4] == CMD_EVAL) |-> (rx_ff[4] < wmod))
      else $error("x corner remainder not below modulus");

   a_rem_y_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && cmd_ff[4] == CMD_EVAL) |-> (ry_ff[4] < hmod))
      else $error("y corner remainder not below modulus");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

endmodule

@@ design/gn2_rem_step.sv @@
// Five restoring remainder steps: shifts in five dividend bits against the modulus.
module gn2_rem_step (
   input  logic [gn2_pkg::MOD_W-1:0]     rem_in,
   input  logic [gn2_pkg::REM_STEPS-1:0] bits_in,
   input  logic [gn2_pkg::MOD_W-1:0]     divisor,
   output logic [gn2_pkg::MOD_W-1:0]     rem_out
);
   import gn2_pkg::*;

   always_comb begin
      logic [MOD_W:0] r;
      r = {1'b0, rem_in};
      for (int i = REM_STEPS - 1; i >= 0; i--) begin
         r = {r[MOD_W-1:0], bits_in[i]};
         if (r >= {1'b0, divisor}) begin
            r = r - {1'b0, divisor};
         end
      end
      rem_out = r[MOD_W-1:0];
   end

endmodule

@@ design/gn2_grad_mem.sv @@
// Gradient table copy: one write port, one registered read port.
module gn2_grad_mem #(
   parameter int DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  gn2_pkg::entry_type            wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output gn2_pkg::entry_type            rd_data
);
   import gn2_pkg::*;

   entry_type mem [0:DEPTH-1];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
